@@ hw/rtl/cac_pkg.sv @@
// shared types and constants for the clipped alpha-over compositor
`default_nettype none
package cac_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned PLACE_W  = 12;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned ADDR_W   = 20;
    localparam int unsigned IN_DW    = 80;
    localparam int unsigned OUT_DW   = 64;
    localparam int unsigned CFG_IDXW = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDXW-1:0] {
        CFG_PLACE_COLUMN = 2'd0,
        CFG_PLACE_ROW    = 2'd1,
        CFG_FRAME_COLS   = 2'd2,
        CFG_FRAME_ROWS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PLACE_W-1:0] place_column;
        logic [PLACE_W-1:0] place_row;
        logic [SIZE_W-1:0]  frame_cols;
        logic [SIZE_W-1:0]  frame_rows;
    } t_cfg;

    localparam logic [SIZE_W-1:0] RST_FRAME_COLS = 11'd320;
    localparam logic [SIZE_W-1:0] RST_FRAME_ROWS = 11'd180;

    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;
    localparam logic [16:0]       ROUND_BIAS = 17'd127;

endpackage
`default_nettype wire

@@ hw/rtl/cac_cfg_regs.sv @@
// placement and frame size configuration registers
`default_nettype none
module cac_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cac_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  wire logic [cac_pkg::PLACE_W-1:0]   i_cfg_data,
    output cac_pkg::t_cfg                      o_cfg
);
    import cac_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.place_column <= '0;
            r_cfg.place_row    <= '0;
            r_cfg.frame_cols   <= RST_FRAME_COLS;
            r_cfg.frame_rows   <= RST_FRAME_ROWS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PLACE_COLUMN: r_cfg.place_column <= i_cfg_data;
                CFG_PLACE_ROW:    r_cfg.place_row    <= i_cfg_data;
                CFG_FRAME_COLS:   r_cfg.frame_cols   <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_ROWS:   r_cfg.frame_rows   <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/cac_blend.sv @@
// one color channel: (fg*a + bg*(255-a) + 127) / 255
`default_nettype none
module cac_blend (
    input  wire logic [cac_pkg::CHAN_W-1:0] i_fg,
    input  wire logic [cac_pkg::CHAN_W-1:0] i_bg,
    input  wire logic [cac_pkg::CHAN_W-1:0] i_alpha,
    output logic      [cac_pkg::CHAN_W-1:0] o_mix
);
    import cac_pkg::*;

    logic [CHAN_W-1:0] inv_alpha;
    logic [16:0]       sum;
    logic [16:0]       q;

    assign inv_alpha = ALPHA_FULL - i_alpha;
    assign sum = {9'd0, i_fg} * {9'd0, i_alpha} + {9'd0, i_bg} * {9'd0, inv_alpha}
               + ROUND_BIAS;
    // exact divide by 255 for sums below 65535
    assign q = sum + 17'd1 + (sum >> 8);
    assign o_mix = q[15:8];

endmodule
`default_nettype wire

@@ hw/rtl/clipped_alpha_over_compositor_unit.sv @@
// Sprite-over-frame compositor: placement, clipping, per-channel alpha blend, frame address.
// Two registers from input transaction to result transaction: input register, then result
// register.
// Throughput: one pixel per cycle while the output is not stalled; blend multipliers and the
// row*width address product sit between the two registers. Clipped pixels are dropped and
// never reach the output. Reset (synchronous, active low) empties both stages, sets
// placement to 0 and the frame to 320 x 180.
`default_nettype none
module clipped_alpha_over_compositor_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // red, green, blue, opacity, bg red, bg green, bg blue, sprite column, sprite row, pad
    input  wire logic [cac_pkg::IN_DW-1:0]     s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // blended red, green, blue, target column, target row, target address
    output logic      [cac_pkg::OUT_DW-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cac_pkg::CFG_IDXW-1:0]  i_cfg_index,
    input  wire logic [cac_pkg::PLACE_W-1:0]   i_cfg_data
);
    import cac_pkg::*;

    t_cfg cfg;

    logic              r_in_valid;
    logic [IN_DW-1:0]  r_in;
    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out;

    logic [CHAN_W-1:0] src_r, src_g, src_b, src_a, bg_r, bg_g, bg_b;
    logic [POS_W-1:0]  spr_col, spr_row;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [12:0]       col, row;
    logic              keep;
    logic [CHAN_W-1:0] mix_r, mix_g, mix_b;
    logic [23:0]       addr_full;
    logic              out_free;
    logic              s1_done;
    logic [OUT_DW-1:0] n_out;

    cac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign src_r   = r_in[7:0];
    assign src_g   = r_in[15:8];
    assign src_b   = r_in[23:16];
    assign src_a   = r_in[31:24];
    assign bg_r    = r_in[39:32];
    assign bg_g    = r_in[47:40];
    assign bg_b    = r_in[55:48];
    assign spr_col = r_in[65:56];
    assign spr_row = r_in[75:66];

    // oversized frame sizes clamp to the maximum
    always_comb begin
        w_eff = cfg.frame_cols;
        h_eff = cfg.frame_rows;
        if (int'(cfg.frame_cols) > MAX_WIDTH) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end
        if (int'(cfg.frame_rows) > MAX_HEIGHT) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
    end

    assign col = {cfg.place_column[PLACE_W-1], cfg.place_column} + {3'b000, spr_col};
    assign row = {cfg.place_row[PLACE_W-1], cfg.place_row} + {3'b000, spr_row};

    assign keep = !col[12] && !row[12]
               && (col[11:0] < {1'b0, w_eff})
               && (row[11:0] < {1'b0, h_eff});

    cac_blend u_blend_r (.i_fg(src_r), .i_bg(bg_r), .i_alpha(src_a), .o_mix(mix_r));
    cac_blend u_blend_g (.i_fg(src_g), .i_bg(bg_g), .i_alpha(src_a), .o_mix(mix_g));
    cac_blend u_blend_b (.i_fg(src_b), .i_bg(bg_b), .i_alpha(src_a), .o_mix(mix_b));

    assign addr_full = {12'd0, row[11:0]} * {13'd0, w_eff} + {12'd0, col[11:0]};

    assign n_out = {addr_full[ADDR_W-1:0], row[POS_W-1:0], col[POS_W-1:0],
                    mix_b, mix_g, mix_r};

    assign out_free      = !r_out_valid || m_axis_tready;
    // clipped pixels leave the input stage without waiting on the output
    assign s1_done       = r_in_valid && (out_free || !keep);
    assign s_axis_tready = !r_in_valid || s1_done;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid && keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
        if (out_free && r_in_valid && keep) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_clipped_alpha_over_compositor_unit.sv @@
// testbench for the clipped alpha-over compositor: self-checking blend and clip stream test
`timescale 1ns / 100ps
module tb_clipped_alpha_over_compositor_unit;
    import cac_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;
    localparam int RANDOM_PHASES = 10;
    localparam int PIXELS_PER_PHASE = 45;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [19:0] address;
    } t_blended_pixel;

    class t_blend_scoreboard;
        logic signed [11:0] place_col;
        logic signed [11:0] place_row;
        logic [10:0]        width;
        logic [10:0]        height;
        t_blended_pixel     awaited_pixels[$];
        int unsigned        errors;

        function new();
            place_col = '0;
            place_row = '0;
            width     = RST_FRAME_COLS;
            height    = RST_FRAME_ROWS;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [11:0] value);
            case (idx)
                CFG_PLACE_COLUMN: place_col = value;
                CFG_PLACE_ROW:    place_row = value;
                CFG_FRAME_COLS:   width = value[10:0];
                CFG_FRAME_ROWS:   height = value[10:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] mix_chan(logic [7:0] fg, logic [7:0] bg, logic [7:0] alpha);
            int unsigned total;
            total = int'(fg) * int'(alpha) + int'(bg) * (int'(ALPHA_FULL) - int'(alpha))
                    + int'(ROUND_BIAS);
            return 8'(total / int'(ALPHA_FULL));
        endfunction

        // accepted input transaction: compute the blend unless the pixel is clipped
        function void note_pixel(logic [79:0] d);
            int             w;
            int             h;
            int             col;
            int             row;
            t_blended_pixel e;
            w   = (width > MAX_W) ? MAX_W : int'(width);
            h   = (height > MAX_H) ? MAX_H : int'(height);
            col = int'(place_col) + int'(d[65:56]);
            row = int'(place_row) + int'(d[75:66]);
            if (col < 0 || row < 0 || col >= w || row >= h)
                return;
            e.red     = mix_chan(d[7:0], d[39:32], d[31:24]);
            e.green   = mix_chan(d[15:8], d[47:40], d[31:24]);
            e.blue    = mix_chan(d[23:16], d[55:48], d[31:24]);
            e.column  = 10'(col);
            e.row     = 10'(row);
            e.address = 20'(row * w + col);
            awaited_pixels.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_blended(logic [63:0] d);
            t_blended_pixel e;
            if (awaited_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            e = awaited_pixels.pop_front();
            compare_field("blended_red", e.red, d[7:0]);
            compare_field("blended_green", e.green, d[15:8]);
            compare_field("blended_blue", e.blue, d[23:16]);
            compare_field("target_column", e.column, d[33:24]);
            compare_field("target_row", e.row, d[43:34]);
            compare_field("target_address", e.address, d[63:44]);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IDXW-1:0] i_cfg_index;
    logic [PLACE_W-1:0]  i_cfg_data;

    t_blend_scoreboard sb;
    int unsigned       burst_left;
    int unsigned       stall_cycle;
    int unsigned       stall_mode;

    clipped_alpha_over_compositor_unit #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver stall pattern with a randomly chosen stall mode
    initial begin
        m_axis_tready = 1'b0;
        stall_cycle   = 0;
        stall_mode    = 0;
    end

    always @(negedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = ($urandom_range(0, 3) != 0);
            2: m_axis_tready = (stall_cycle % 8 < 5);
            default: m_axis_tready = ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_blended(m_axis_tdata);
    end

    function automatic logic [79:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] a, logic [7:0] br, logic [7:0] bgr,
                                               logic [7:0] bb, logic [9:0] col,
                                               logic [9:0] row);
        return {4'b0, row, col, bb, bgr, br, a, b, g, r};
    endfunction

    function automatic logic [7:0] pick_opacity();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'd0;
        if (sel == 1)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // sprite coordinate that mostly lands near or inside the frame
    function automatic logic [9:0] aim_coord(int place, int extent);
        int t;
        int s;
        if ($urandom_range(0, 4) == 0)
            return 10'($urandom_range(0, 1023));
        t = int'($urandom_range(0, extent + 3)) - 2;
        s = t - place;
        if (s < 0 || s > 1023)
            return 10'($urandom_range(0, 1023));
        return 10'(s);
    endfunction

    task automatic send_pixel(logic [79:0] d);
        if (burst_left == 0) begin
            int unsigned gap;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = '0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pixel(d);
    endtask

    task automatic send_random_colors(logic [9:0] col, logic [9:0] row);
        send_pixel(pack_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_opacity(),
                              8'($urandom), 8'($urandom), 8'($urandom), col, row));
    endtask

    // stop the stream and let every pending pixel come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        while (sb.awaited_pixels.size() != 0) @(posedge i_clk);
        // clipped pixels may still sit in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [11:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(int pc, int pr, int w, int h);
        drain();
        write_reg(CFG_PLACE_COLUMN, 12'(pc));
        write_reg(CFG_PLACE_ROW, 12'(pr));
        write_reg(CFG_FRAME_COLS, 12'(w));
        write_reg(CFG_FRAME_ROWS, 12'(h));
    endtask

    function automatic int pick_place();
        int unsigned sel;
        sel = $urandom_range(0, 4);
        if (sel < 3)
            return int'($urandom_range(0, 64)) - 32;
        if (sel == 3)
            return int'($urandom_range(0, 2048)) - 1024;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel < 3)
            return 1;
        if (sel < 5)
            return MAX_W;
        if (sel < 7)
            return int'($urandom_range(MAX_W + 1, 2047));
        if (sel < 12)
            return int'($urandom_range(1, 48));
        return int'($urandom_range(1, MAX_W));
    endfunction

    initial begin
        int pc;
        int pr;
        int w;
        int h;
        int n;
        sb            = new();
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset frame of 320 x 180 at offset zero
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                              10'd319, 10'd179));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 10'd5, 10'd7));
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 10'd9, 10'd2));
        send_pixel(pack_pixel(8'd255, 8'd128, 8'd1, 8'd128, 8'd0, 8'd127, 8'd254, 10'd3, 10'd3));
        send_pixel(pack_pixel(8'd0, 8'd170, 8'd85, 8'd1, 8'd255, 8'd85, 8'd170, 10'd4, 10'd1));
        send_random_colors(10'd320, 10'd0);
        send_random_colors(10'd0, 10'd180);
        send_random_colors(10'd1023, 10'd1023);

        // negative placement clips the first sprite column and row
        configure(-1, -1, MAX_W, MAX_H);
        send_random_colors(10'd0, 10'd5);
        send_random_colors(10'd1, 10'd1);
        send_random_colors(10'd1023, 10'd1023);
        send_random_colors(10'd1023, 10'd0);

        // oversized frame falls back to the maximum
        configure(0, 0, 2047, 2047);
        send_random_colors(10'd1023, 10'd1023);
        send_random_colors(10'd1023, 10'd0);

        // empty frame, then a single-pixel frame
        configure(0, 0, 0, 5);
        send_random_colors(10'd0, 10'd0);
        configure(0, 0, 1, 1);
        send_random_colors(10'd0, 10'd0);
        send_random_colors(10'd1, 10'd0);
        send_random_colors(10'd0, 10'd1);

        // placement extremes
        configure(-2048, 2047, MAX_W, MAX_H);
        send_random_colors(10'd1023, 10'd1023);
        configure(2047, -2048, MAX_W, MAX_H);
        send_random_colors(10'd0, 10'd1023);
        configure(-1024, 1024, MAX_W, MAX_H);
        send_random_colors(10'd1023, 10'd0);
        configure(1024, 0, MAX_W, MAX_H);
        send_random_colors(10'd0, 10'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pc = pick_place();
            pr = pick_place();
            w  = pick_size();
            h  = pick_size();
            configure(pc, pr, w, h);
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
                send_random_colors(aim_coord(pc, (w > MAX_W) ? MAX_W : w),
                                   aim_coord(pr, (h > MAX_H) ? MAX_H : h));
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        n = 0;
        while (sb.awaited_pixels.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.awaited_pixels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.awaited_pixels.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ clipped_alpha_over_compositor_unit.f @@
hw/rtl/cac_pkg.sv
hw/rtl/cac_cfg_regs.sv
hw/rtl/cac_blend.sv
hw/rtl/clipped_alpha_over_compositor_unit.sv
tb/tb_clipped_alpha_over_compositor_unit.sv
